// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define KNPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define KNPS_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/knps_pkg.sv -----
// Types and fixed widths for the k-nearest point selector.
package knps_pkg;

    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int DIST_W  = 50;
    localparam int INDEX_W = 10;
    localparam int RANK_W  = 3;
    localparam int KEEP_W  = 4;

    localparam logic [KEEP_W-1:0] KEEP_RESET = 4'd8;

    // One entry of the sorted list.
    typedef struct packed {
        logic [DIST_W-1:0]  sq_dist;
        logic [INDEX_W-1:0] index;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_PLACE,
        ST_SCAN,
        ST_FRONT,
        ST_FINISH,
        ST_EMIT,
        ST_EMIT_LOAD
    } state_t;

    // Magnitude of the difference of two signed coordinates.
    function automatic logic [DIFF_W-1:0] abs_diff(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        logic [DIFF_W-1:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[DIFF_W-1] ? (~d + 1'b1) : d;
    endfunction

endpackage

// ----- rtl/k_nearest_point_select.sv -----
// Top level: streaming k-nearest point selector over a sorted list in RAM.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  probe in | in_valid / in_ready  | query_x/y/z, probe_x/y/z, last_probe
//  result   | out_valid/out_ready  | probe_index, rank, distance_squared,
//           |                      | last_result
//  config   | cfg_write            | cfg_data (keep_count)
//
// A probe passes the square, sum and place states, then walks the list from the far
// end, one entry per scan step, through the single read port of the list RAM, with a
// front step when it lands at the front.
// Each result is read from the RAM, then loaded into the output register once that is free.
// in_ready is high only in idle; only a waiting last result does not block the next probe.
// Reset clears counters and keep_count (to 8); the list RAM is not cleared.
// A stalled output holds emission in place; no word is dropped.

`include "assert_macros.svh"

module k_nearest_point_select #(
    parameter int KEEP_MAX   = 8,
    parameter int MAX_PROBES = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [knps_pkg::COORD_W-1:0] query_x,
    input  logic signed [knps_pkg::COORD_W-1:0] query_y,
    input  logic signed [knps_pkg::COORD_W-1:0] query_z,
    input  logic signed [knps_pkg::COORD_W-1:0] probe_x,
    input  logic signed [knps_pkg::COORD_W-1:0] probe_y,
    input  logic signed [knps_pkg::COORD_W-1:0] probe_z,
    input  logic                              last_probe,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [knps_pkg::INDEX_W-1:0]      probe_index,
    output logic [knps_pkg::RANK_W-1:0]       rank,
    output logic [knps_pkg::DIST_W-1:0]       distance_squared,
    output logic                              last_result,
    input  logic                              cfg_write,
    input  logic [knps_pkg::KEEP_W-1:0]       cfg_data
);
    import knps_pkg::*;

    localparam int IDX_W  = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1;
    localparam int FILL_W = $clog2(KEEP_MAX + 1);
    localparam int CNT_W  = $clog2(MAX_PROBES + 1);

    localparam logic [IDX_W-1:0]  LAST_ADDR  = IDX_W'(KEEP_MAX - 1);
    localparam logic [FILL_W-1:0] FILL_MAX   = FILL_W'(KEEP_MAX);
    localparam logic [CNT_W-1:0]  PROBE_MAX  = CNT_W'(MAX_PROBES);
    localparam logic [7:0]        KEEP_MAX_W = 8'(KEEP_MAX);

    // control state
    state_t              state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]    arrival_reg, arrival_next;
    logic [KEEP_W-1:0]   keep_count_reg;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic [FILL_W-1:0]   emit_ptr_reg, emit_ptr_next;
    logic [FILL_W-1:0]   emit_count_reg, emit_count_next;
    logic                out_valid_reg, out_valid_next;

    // datapath registers
    logic [DIFF_W-1:0]   dax_reg, day_reg, daz_reg;
    logic [DIST_W-1:0]   sqx_reg, sqy_reg, sqz_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic                last_reg;
    logic                measure_reg;
    entry_t              rd_data_reg;

    logic [INDEX_W-1:0]  out_index_reg;
    logic [RANK_W-1:0]   out_rank_reg;
    logic [DIST_W-1:0]   out_dist_reg;
    logic                out_last_reg;

    // list RAM and its ports
    entry_t              mem [KEEP_MAX];
    logic                rd_en, wr_en;
    logic [IDX_W-1:0]    rd_addr, wr_addr;
    entry_t              wr_data;

    logic                load_out;
    logic                emit_last;
    logic [7:0]          kc_wide;
    logic [FILL_W-1:0]   want;
    logic [FILL_W-1:0]   count;

    assign in_ready         = (state_reg == ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign probe_index      = out_index_reg;
    assign rank             = out_rank_reg;
    assign distance_squared = out_dist_reg;
    assign last_result      = out_last_reg;

    assign emit_last = (FILL_W'(emit_ptr_reg + 1'b1) == emit_count_reg);

    // clamp keep_count to 1..KEEP_MAX and cut to the fill
    always_comb
    begin
        kc_wide = {4'b0000, keep_count_reg};
        if (kc_wide == 8'd0)
            want = FILL_W'(1);
        else if (kc_wide > KEEP_MAX_W)
            want = FILL_MAX;
        else
            want = FILL_W'(kc_wide);
        count = (fill_reg < want) ? fill_reg : want;
    end

    // next state, RAM controls
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        arrival_next    = arrival_reg;
        ptr_next        = ptr_reg;
        emit_ptr_next   = emit_ptr_reg;
        emit_count_next = emit_count_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '{sq_dist: dist_reg, index: idx_reg};
        load_out        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_SQUARE;
            end
            ST_SQUARE:
                state_next = ST_SUM;
            ST_SUM:
                state_next = ST_PLACE;
            ST_PLACE:
            begin
                if (!measure_reg)
                    state_next = ST_FINISH;
                else
                begin
                    arrival_next = CNT_W'(arrival_reg + 1'b1);
                    if (fill_reg < FILL_MAX)
                        fill_next = FILL_W'(fill_reg + 1'b1);
                    if (fill_reg == '0)
                    begin
                        // empty list: first entry goes straight in
                        wr_en      = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        // start the walk at the farthest entry
                        rd_en      = 1'b1;
                        rd_addr    = IDX_W'(fill_reg - 1'b1);
                        ptr_next   = IDX_W'(fill_reg - 1'b1);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // writes go one slot above the entry just read, above the next read, so they never collide
                if (rd_data_reg.sq_dist > dist_reg)
                begin
                    if (ptr_reg != LAST_ADDR)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = IDX_W'(ptr_reg + 1'b1);
                        wr_data = rd_data_reg;
                    end
                    if (ptr_reg == '0)
                        state_next = ST_FRONT;
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = IDX_W'(ptr_reg - 1'b1);
                        ptr_next = IDX_W'(ptr_reg - 1'b1);
                    end
                end
                else
                begin
                    // ties stay ahead of the new word
                    if (ptr_reg != LAST_ADDR)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = IDX_W'(ptr_reg + 1'b1);
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_FRONT:
            begin
                wr_en      = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!last_reg)
                    state_next = ST_IDLE;
                else if (count == '0)
                begin
                    fill_next    = '0;
                    arrival_next = '0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    emit_ptr_next   = '0;
                    emit_count_next = count;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(emit_ptr_reg);
                state_next = ST_EMIT_LOAD;
            end
            ST_EMIT_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out = 1'b1;
                    if (emit_last)
                    begin
                        fill_next    = '0;
                        arrival_next = '0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        emit_ptr_next = FILL_W'(emit_ptr_reg + 1'b1);
                        state_next    = ST_EMIT;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        out_valid_next = out_valid_reg && !out_ready;
        if (load_out)
            out_valid_next = 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            arrival_reg    <= '0;
            keep_count_reg <= KEEP_RESET;
            ptr_reg        <= '0;
            emit_ptr_reg   <= '0;
            emit_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            arrival_reg    <= arrival_next;
            ptr_reg        <= ptr_next;
            emit_ptr_reg   <= emit_ptr_next;
            emit_count_reg <= emit_count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_write)
                keep_count_reg <= cfg_data;
        end
    end

    // distance pipeline: |diff|, squares, sum
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            dax_reg     <= abs_diff(probe_x, query_x);
            day_reg     <= abs_diff(probe_y, query_y);
            daz_reg     <= abs_diff(probe_z, query_z);
            idx_reg     <= INDEX_W'(arrival_reg);
            last_reg    <= last_probe;
            measure_reg <= (arrival_reg < PROBE_MAX);
        end
        if (state_reg == ST_SQUARE)
        begin
            sqx_reg <= dax_reg * dax_reg;
            sqy_reg <= day_reg * day_reg;
            sqz_reg <= daz_reg * daz_reg;
        end
        if (state_reg == ST_SUM)
            dist_reg <= DIST_W'(sqx_reg + sqy_reg + sqz_reg);
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_index_reg <= rd_data_reg.index;
            out_rank_reg  <= RANK_W'(emit_ptr_reg);
            out_dist_reg  <= rd_data_reg.sq_dist;
            out_last_reg  <= emit_last;
        end
    end

    // sorted list RAM, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // checks
    `KNPS_ASSERT(a_fill_bound, fill_reg <= FILL_MAX, "list fill above capacity")
    `KNPS_NEVER(a_ram_overlap, wr_en && rd_en && (wr_addr == rd_addr), "RAM read/write collide")
    `KNPS_ASSERT(a_out_source, $rose(out_valid_reg) |-> ($past(state_reg) == ST_EMIT_LOAD), "result not from emit")
    `KNPS_ASSERT(a_run_clear, (load_out && emit_last) |=> (fill_reg == '0 && arrival_reg == '0), "run not cleared")

endmodule

// ----- tb/knps_result_checker.sv -----
// Result checker for the k-nearest point selector: predicts and compares output words.
module knps_result_checker #(
    parameter int KEEP_MAX   = 8,
    parameter int MAX_PROBES = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [knps_pkg::COORD_W-1:0] query_x,
    input  logic signed [knps_pkg::COORD_W-1:0] query_y,
    input  logic signed [knps_pkg::COORD_W-1:0] query_z,
    input  logic signed [knps_pkg::COORD_W-1:0] probe_x,
    input  logic signed [knps_pkg::COORD_W-1:0] probe_y,
    input  logic signed [knps_pkg::COORD_W-1:0] probe_z,
    input  logic                                last_probe,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [knps_pkg::INDEX_W-1:0]        probe_index,
    input  logic [knps_pkg::RANK_W-1:0]         rank,
    input  logic [knps_pkg::DIST_W-1:0]         distance_squared,
    input  logic                                last_result,
    input  logic                                cfg_write,
    input  logic [knps_pkg::KEEP_W-1:0]         cfg_data,
    output int                                  fail_count,
    output int                                  pending_count,
    output int                                  results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import knps_pkg::*;

    // One expected output word
    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [RANK_W-1:0]  rank;
        logic [DIST_W-1:0]  sq_dist;
        logic               last;
    } ranked_point_t;

    // Shadow of the block: sorted nearest list, counters, keep setting
    entry_t            nearest_list [KEEP_MAX];
    int                list_fill;
    int                arrivals;
    logic [KEEP_W-1:0] keep_setting;
    ranked_point_t     expected_points [$];
    int                mismatches;
    int                words_seen;

    // Squared Euclidean distance, exact in 50 bits
    function automatic logic [DIST_W-1:0] squared_distance(
        input logic signed [COORD_W-1:0] px, py, pz, qx, qy, qz
    );
        longint dx, dy, dz;
        dx = longint'(px) - longint'(qx);
        dy = longint'(py) - longint'(qy);
        dz = longint'(pz) - longint'(qz);
        return DIST_W'(dx * dx + dy * dy + dz * dz);
    endfunction

    // Insert after all equal distances; a tie with the farthest of a full list is dropped
    function automatic void insert_nearest(input logic [DIST_W-1:0] sq_dist,
                                           input logic [INDEX_W-1:0] idx);
        int pos;
        int top;
        pos = 0;
        while (pos < list_fill && nearest_list[pos].sq_dist <= sq_dist)
            pos++;
        if (pos >= KEEP_MAX)
            return;
        top = (list_fill < KEEP_MAX) ? list_fill : KEEP_MAX - 1;
        for (int i = top; i > pos; i--)
            nearest_list[i] = nearest_list[i - 1];
        nearest_list[pos].sq_dist = sq_dist;
        nearest_list[pos].index   = idx;
        if (list_fill < KEEP_MAX)
            list_fill++;
    endfunction

    // Queue the nearest entries of the run, then clear the counters
    function automatic void emit_nearest();
        int want;
        int count;
        ranked_point_t point;
        want = int'(keep_setting);
        if (want < 1)
            want = 1;
        if (want > KEEP_MAX)
            want = KEEP_MAX;
        count = (list_fill < want) ? list_fill : want;
        for (int r = 0; r < count; r++)
        begin
            point.index   = nearest_list[r].index;
            point.rank    = RANK_W'(r);
            point.sq_dist = nearest_list[r].sq_dist;
            point.last    = (r + 1 == count);
            expected_points = {expected_points, point};
        end
        list_fill = 0;
        arrivals  = 0;
    endfunction

    // Field-by-field compare against the oldest expectation
    function automatic void compare_result();
        ranked_point_t point;
        bit bad;
        words_seen++;
        if (expected_points.size() == 0)
        begin
            $error("unexpected result word: probe_index %0d rank %0d distance_squared %0d",
                   probe_index, rank, distance_squared);
            mismatches++;
            return;
        end
        point = expected_points.pop_front();
        bad = 0;
        if (probe_index !== point.index)
        begin
            $error("probe_index: expected %0d, got %0d", point.index, probe_index);
            bad = 1;
        end
        if (rank !== point.rank)
        begin
            $error("rank: expected %0d, got %0d", point.rank, rank);
            bad = 1;
        end
        if (distance_squared !== point.sq_dist)
        begin
            $error("distance_squared: expected %0d, got %0d", point.sq_dist, distance_squared);
            bad = 1;
        end
        if (last_result !== point.last)
        begin
            $error("last_result: expected %0d, got %0d", point.last, last_result);
            bad = 1;
        end
        if (bad)
            mismatches++;
    endfunction

    // Watch config, probe and result channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_fill    = 0;
            arrivals     = 0;
            keep_setting = KEEP_RESET;
            expected_points.delete();
            mismatches   = 0;
            words_seen   = 0;
            fail_count      <= 0;
            pending_count   <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (cfg_write)
                keep_setting = cfg_data;
            if (in_valid && in_ready)
            begin
                // probes past the capacity are neither measured nor counted
                if (arrivals < MAX_PROBES)
                begin
                    insert_nearest(squared_distance(probe_x, probe_y, probe_z,
                                                    query_x, query_y, query_z),
                                   INDEX_W'(arrivals));
                    arrivals++;
                end
                if (last_probe)
                    emit_nearest();
            end
            if (out_valid && out_ready)
                compare_result();
            fail_count      <= mismatches;
            pending_count   <= expected_points.size();
            results_checked <= words_seen;
        end
    end

endmodule

// ----- tb/k_nearest_point_select_test.sv -----
// Testbench top for the k-nearest point selector: stimulus, result stalls and verdict.
module k_nearest_point_select_test;
    timeunit 1ns;
    timeprecision 1ps;

    import knps_pkg::*;

    localparam int KEEP_MAX     = 8;
    localparam int MAX_PROBES   = 1024;
    localparam int RANDOM_ITEMS = 394;
    localparam int IDLE_SETTLE  = 24;   // longer than the longest probe
    localparam int END_DRAIN    = 40;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

    localparam logic [KEEP_W-1:0] KEEP_ZERO = 4'd0;
    localparam logic [KEEP_W-1:0] KEEP_ONE  = 4'd1;
    localparam logic [KEEP_W-1:0] KEEP_TWO  = 4'd2;
    localparam logic [KEEP_W-1:0] KEEP_FULL = 4'd8;
    localparam logic [KEEP_W-1:0] KEEP_TOP  = 4'd15;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [COORD_W-1:0] query_x, query_y, query_z;
    logic signed [COORD_W-1:0] probe_x, probe_y, probe_z;
    logic last_probe;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [INDEX_W-1:0] probe_index;
    logic [RANK_W-1:0]  rank;
    logic [DIST_W-1:0]  distance_squared;
    logic last_result;
    logic cfg_write;
    logic [KEEP_W-1:0] cfg_data;

    int fail_count;
    int pending_count;
    int results_checked;

    bit burst;          // no gaps on either side while set
    int ready_hold = 0;
    int probes_sent;
    int runs_sent;
    int keep_writes;

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    k_nearest_point_select #(
        .KEEP_MAX   (KEEP_MAX),
        .MAX_PROBES (MAX_PROBES)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .query_x          (query_x),
        .query_y          (query_y),
        .query_z          (query_z),
        .probe_x          (probe_x),
        .probe_y          (probe_y),
        .probe_z          (probe_z),
        .last_probe       (last_probe),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .probe_index      (probe_index),
        .rank             (rank),
        .distance_squared (distance_squared),
        .last_result      (last_result),
        .cfg_write        (cfg_write),
        .cfg_data         (cfg_data)
    );

    knps_result_checker #(
        .KEEP_MAX   (KEEP_MAX),
        .MAX_PROBES (MAX_PROBES)
    ) result_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .query_x          (query_x),
        .query_y          (query_y),
        .query_z          (query_z),
        .probe_x          (probe_x),
        .probe_y          (probe_y),
        .probe_z          (probe_z),
        .last_probe       (last_probe),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .probe_index      (probe_index),
        .rank             (rank),
        .distance_squared (distance_squared),
        .last_result      (last_result),
        .cfg_write        (cfg_write),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .pending_count    (pending_count),
        .results_checked  (results_checked)
    );

    function automatic int draw_gap();
        return burst ? 0 : $urandom_range(0, 15);
    endfunction

    // Result side: after each accepted word, drop out_ready for a random gap (none in burst)
    always @(posedge clk or negedge rst_n)
    begin
        int gap;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            ready_hold <= 0;
        end
        else if (out_ready && out_valid)
        begin
            gap = draw_gap();
            ready_hold <= gap;
            if (gap != 0)
                out_ready <= 1'b0;
        end
        else if (!out_ready)
        begin
            if (ready_hold <= 1)
                out_ready <= 1'b1;
            ready_hold <= ready_hold - 1;
        end
    end

    // Send one probe word after a random gap; returns at the accepting edge
    task automatic send_probe(input point_t query, input point_t probe, input logic last);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        query_x    <= query.x;
        query_y    <= query.y;
        query_z    <= query.z;
        probe_x    <= probe.x;
        probe_y    <= probe.y;
        probe_z    <= probe.z;
        last_probe <= last;
        do
            @(posedge clk);
        while (!in_ready);
        probes_sent++;
        if (last)
            runs_sent++;
    endtask

    // Wait until every expected word is out and the block has settled
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic write_keep(input logic [KEEP_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        keep_writes++;
    endtask

    function automatic logic [KEEP_W-1:0] pick_keep();
        case ($urandom_range(0, 5))
            0: return KEEP_ZERO;
            1: return KEEP_ONE;
            2: return KEEP_FULL;
            3: return KEEP_TOP;
            default: return KEEP_W'($urandom_range(0, 15));
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return COORD_W'(int'($urandom_range(0, 511)) - 256);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic point_t random_point();
        point_t p;
        case ($urandom_range(0, 2))
            0:
            begin
                p.x = COORD_W'($urandom);
                p.y = COORD_W'($urandom);
                p.z = COORD_W'($urandom);
            end
            1:
            begin
                p.x = COORD_W'(int'($urandom_range(0, 511)) - 256);
                p.y = COORD_W'(int'($urandom_range(0, 511)) - 256);
                p.z = COORD_W'(int'($urandom_range(0, 511)) - 256);
            end
            default:
            begin
                p.x = pick_coord();
                p.y = pick_coord();
                p.z = pick_coord();
            end
        endcase
        return p;
    endfunction

    // Mostly probes clustered on the query or repeated, so ties and reordering happen
    function automatic point_t next_probe(input point_t query, input point_t previous);
        point_t p;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: p = random_point();
            4, 5, 6:
            begin
                p.x = query.x + COORD_W'(int'($urandom_range(0, 6)) - 3);
                p.y = query.y + COORD_W'(int'($urandom_range(0, 6)) - 3);
                p.z = query.z + COORD_W'(int'($urandom_range(0, 6)) - 3);
            end
            7, 8: p = previous;
            default: p = query;
        endcase
        return p;
    endfunction

    // Run out of time: fail
    initial
    begin
        #5_000_000;
        $display("** k_nearest_point_select: FAILED **");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin
        point_t q;
        point_t p;
        point_t prev;
        int run_len;
        int random_sent;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        query_x    = '0;
        query_y    = '0;
        query_z    = '0;
        probe_x    = '0;
        probe_y    = '0;
        probe_z    = '0;
        last_probe = 1'b0;
        cfg_write  = 1'b0;
        cfg_data   = '0;
        burst      = 0;
        probes_sent = 0;
        runs_sent   = 0;
        keep_writes = 0;
        random_sent = 0;
        prev = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fewer points than keep_count, extreme coordinates, zero and largest distance
        q = '{COORD_MIN, COORD_MIN, COORD_MIN};
        send_probe(q, '{COORD_MAX, COORD_MAX, COORD_MAX}, 1'b0);
        send_probe(q, '{COORD_MIN, COORD_MIN, COORD_MIN}, 1'b0);
        send_probe(q, '{COORD_MAX, COORD_MIN, COORD_MIN}, 1'b1);

        // Query changes in the middle of a run
        send_probe('{COORD_MAX, COORD_MAX, COORD_MAX}, '{COORD_MIN, COORD_MIN, COORD_MIN}, 1'b0);
        send_probe('{24'sd0, 24'sd0, 24'sd0}, '{-24'sd1, -24'sd1, -24'sd1}, 1'b0);
        send_probe('{COORD_MAX, 24'sd0, COORD_MIN}, '{COORD_MAX, 24'sd0, COORD_MIN}, 1'b1);

        // Equal distances fill the list; a tie with the farthest is dropped,
        // then a nearer point pushes the farthest out
        q = '0;
        repeat (9) send_probe(q, '{24'sd1, -24'sd2, 24'sd3}, 1'b0);
        send_probe(q, '{24'sd0, 24'sd0, 24'sd1}, 1'b1);

        // keep_count changed mid-run: the value on the last probe counts
        wait_idle();
        for (int i = 0; i < 3; i++)
            send_probe(random_point(), random_point(), 1'b0);
        wait_idle();
        write_keep(KEEP_TWO);
        send_probe(q, random_point(), 1'b0);
        send_probe(q, random_point(), 1'b1);

        // Out-of-range settings: zero acts as one, above the list size as full
        wait_idle();
        write_keep(KEEP_ZERO);
        send_probe(q, random_point(), 1'b0);
        send_probe(q, random_point(), 1'b1);
        wait_idle();
        write_keep(KEEP_TOP);
        send_probe(q, random_point(), 1'b1);
        wait_idle();
        write_keep(KEEP_ONE);
        send_probe(q, '{24'sd5, 24'sd5, 24'sd5}, 1'b0);
        send_probe(q, '{24'sd4, 24'sd4, 24'sd4}, 1'b1);
        wait_idle();
        write_keep(KEEP_FULL);

        // Random runs with random keep settings and gaps
        while (random_sent < RANDOM_ITEMS)
        begin
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 10);
            burst = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0)
            begin
                wait_idle();
                write_keep(pick_keep());
            end
            q = random_point();
            for (int k = 0; k < run_len; k++)
            begin
                if ($urandom_range(0, 15) == 0)
                    q = random_point();
                if (k > 0 && $urandom_range(0, 40) == 0)
                begin
                    wait_idle();
                    write_keep(pick_keep());
                end
                p = next_probe(q, prev);
                send_probe(q, p, k == run_len - 1);
                prev = p;
                random_sent++;
            end
        end
        burst = 0;

        // Drain
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (END_DRAIN) @(posedge clk);

        $display("Covered %0d probe words in %0d runs, %0d keep_count writes,",
                 probes_sent, runs_sent, keep_writes);
        $display("with ties, extreme points and stalls; %0d result words checked.",
                 results_checked);
        if (fail_count == 0 && pending_count == 0)
            $display("** k_nearest_point_select: PASSED **");
        else
            $display("** k_nearest_point_select: FAILED **");
        $finish;
    end

endmodule

// ----- k_nearest_point_select.f -----
+incdir+rtl
rtl/knps_pkg.sv
rtl/k_nearest_point_select.sv
tb/knps_result_checker.sv
tb/k_nearest_point_select_test.sv
